// ===== hdl/whe_pkg.sv =====
// shared types, constants and register codes of the waveform hit extractor
`default_nettype none

package whe_pkg;

	// default channel count and field widths
	localparam int CHANNELS_DEF = 48;
	localparam int POS_W        = 6;
	localparam int CHAN_W       = 6;
	localparam int DATA_W       = 32;
	localparam int SHORT_W      = 16;
	localparam int TIME_W       = 15;
	localparam int ENTRY_W      = 2 * TIME_W;

	// tdc short decoding
	localparam logic [TIME_W-1:0]  NO_TIME   = 15'h7fff;
	localparam logic [SHORT_W-1:0] VALID_BIT = 16'h8000;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// configuration register indexes
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_ADC_THRESHOLD = 2'd0;
	localparam reg_idx_t REG_TIME_OFFSET   = 2'd1;
	localparam reg_idx_t REG_TRIGGER_TIME  = 2'd2;

	// configuration reset values
	localparam logic [SHORT_W-1:0] ADC_THRESHOLD_RST = 16'd10;
	localparam logic [SHORT_W-1:0] TIME_OFFSET_RST   = 16'd5562;
	localparam logic [SHORT_W-1:0] TRIGGER_TIME_RST  = 16'd0;

	typedef logic [CHAN_W-1:0] chan_t;

	// word classes seen by the back end
	typedef enum logic [1:0] {
		KIND_DATA,
		KIND_END,
		KIND_ERR
	} kind_t;

	typedef struct packed {
		logic [DATA_W-1:0] data_word;
		logic              last_word;
	} pay_word_t;

	typedef struct packed {
		chan_t              channel;
		logic [SHORT_W-1:0] drift_time;
		logic [SHORT_W-1:0] adc_sum;
		logic [SHORT_W-1:0] second_time;
		logic               last_hit;
		logic               length_error;
	} hit_word_t;

	typedef struct packed {
		logic [SHORT_W-1:0] adc_threshold;
		logic [SHORT_W-1:0] time_offset;
		logic [SHORT_W-1:0] trigger_time;
	} cfg_t;

	typedef struct packed {
		logic [DATA_W-1:0] data_word;
		logic [POS_W-1:0]  pos;
		kind_t             kind;
	} qent_t;

endpackage

`default_nettype wire

// ===== hdl/whe_ram.sv =====
// generic ram: one write port, two registered read ports
`default_nettype none

module whe_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 48
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     rea,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic                     reb,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		if (rea) begin
			rdata_a <= mem_q[raddr_a];
		end
		if (reb) begin
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/whe_front.sv =====
// front end: takes payload words, tracks the word position and classifies them
`default_nettype none

module whe_front #(
	parameter int CHANNELS = whe_pkg::CHANNELS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               pay_valid,
	output logic                    pay_stall,
	input  wire whe_pkg::pay_word_t pay_word,
	input  wire logic               q_full,
	output logic                    q_push,
	output whe_pkg::qent_t          q_entry
);

	localparam int CW = $clog2(CHANNELS);
	localparam int PW = whe_pkg::POS_W;

	logic [CW-1:0] pos_q;
	logic [CW-1:0] pos_next;

	assign pay_stall = q_full;
	assign q_push    = pay_valid && !q_full;

	// position after this word, wrapping at the end of a sample
	assign pos_next = (pos_q == CW'(CHANNELS - 1)) ? '0 : pos_q + 1'b1;

	// classify the word for the back end
	always_comb begin
		q_entry.data_word = pay_word.data_word;
		q_entry.pos       = PW'(pos_q);
		if (!pay_word.last_word) begin
			q_entry.kind = whe_pkg::KIND_DATA;
		end else if (pos_next != '0) begin
			q_entry.kind = whe_pkg::KIND_ERR;
		end else begin
			q_entry.kind = whe_pkg::KIND_END;
		end
	end

	// word position counter, back to zero at packet end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (q_push) begin
			pos_q <= pay_word.last_word ? '0 : pos_next;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/whe_queue.sv =====
// short fifo of classified words between front and back
`default_nettype none

module whe_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire whe_pkg::qent_t push_entry,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output whe_pkg::qent_t      head_entry
);

	localparam int QD  = whe_pkg::QDEPTH;
	localparam int QAW = whe_pkg::QAW;

	whe_pkg::qent_t mem_q [QD];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full       = (count_q == (QAW + 1)'(QD));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/whe_back.sv =====
// back end: per-channel accumulation in ram, end-of-packet scan and hit output
`default_nettype none

module whe_back #(
	parameter int CHANNELS = whe_pkg::CHANNELS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire whe_pkg::cfg_t  cfg,
	input  wire logic           q_valid,
	input  wire whe_pkg::qent_t q_entry,
	output logic                q_pop,
	output logic                hit_valid,
	input  wire logic           hit_stall,
	output whe_pkg::hit_word_t  hit_word
);

	localparam int CW = $clog2(CHANNELS);
	localparam int SW = CW + 1;
	localparam int EW = whe_pkg::ENTRY_W;
	localparam int TW = whe_pkg::TIME_W;
	localparam int HW = whe_pkg::SHORT_W;

	localparam logic [EW-1:0] TDC_RST = {whe_pkg::NO_TIME, whe_pkg::NO_TIME};

	typedef enum logic [2:0] {
		ST_RUN  = 3'b001,
		ST_SCAN = 3'b010,
		ST_ERR  = 3'b100
	} st_t;

	st_t state_q;

	// accumulation stage
	logic                       acc_valid_s1;
	logic [whe_pkg::DATA_W-1:0] acc_word_s1;
	logic [CW-1:0]              acc_row_s1;
	whe_pkg::kind_t             acc_kind_s1;

	// row valid bits per bank, hit mask per channel
	logic [CHANNELS-1:0] vld_q [2];
	logic [CHANNELS-1:0] hit_mask_q;

	// scan control
	logic          scan_issue_q;
	logic [CW-1:0] scan_ch_q;
	logic          sc_valid_s1;
	logic [CW-1:0] sc_ch_s1;

	// output register
	logic               hit_valid_q;
	whe_pkg::hit_word_t hit_word_q;

	// ram ports
	logic          rd_en_a;
	logic          rd_en_b;
	logic [CW-1:0] rd_addr_a;
	logic [CW-1:0] rd_addr_b;
	logic [EW-1:0] rd_a [2];
	logic [EW-1:0] rd_b [2];

	// lane signals, lane 0 is the high short
	logic [SW-1:0] lane_slot  [2];
	logic [HW-1:0] lane_short [2];
	logic [TW-1:0] lane_t     [2];
	logic [EW-1:0] lane_old   [2];
	logic [EW-1:0] lane_new   [2];
	logic          lane_hit   [2];
	logic [CW-1:0] lane_ch    [2];

	// scan read addressing
	logic [SW-1:0] scan_sum_slot;
	logic [SW-1:0] scan_tdc_slot;
	logic [SW-1:0] sc_sum_slot;
	logic [SW-1:0] sc_tdc_slot;
	logic [EW-1:0] sc_tdc;
	logic [HW-1:0] sc_sum;
	logic [HW-1:0] sc_fast;
	logic [HW-1:0] sc_base;
	logic [HW-1:0] sc_drift;
	logic          sc_hit;
	logic          sc_last;
	logic          out_free;
	logic          scan_adv;
	logic          scan_issue;
	logic          hit_load;
	whe_pkg::chan_t sc_chan;

	assign hit_valid = hit_valid_q;
	assign hit_word  = hit_word_q;
	assign out_free  = !hit_valid_q || !hit_stall;

	// pop only while accumulating and no packet end is in flight
	assign q_pop = q_valid && (state_q == ST_RUN)
		&& !(acc_valid_s1 && (acc_kind_s1 != whe_pkg::KIND_DATA));

	// scan stage advances unless a hit waits for the output register
	assign sc_hit     = sc_valid_s1 && hit_mask_q[sc_ch_s1];
	assign scan_adv   = !sc_hit || out_free;
	assign scan_issue = (state_q == ST_SCAN) && scan_issue_q && scan_adv;

	// a new word enters the output register
	assign hit_load = out_free && ((state_q == ST_ERR) || (state_q == ST_SCAN && sc_hit));

	// scan addresses: adc slot is the channel, tdc slot follows all adc slots
	assign scan_sum_slot = SW'(scan_ch_q);
	assign scan_tdc_slot = SW'(scan_ch_q) + SW'(CHANNELS);

	// read port a serves accumulation and the adc half of the scan
	always_comb begin
		rd_en_a   = q_pop || scan_issue;
		rd_addr_a = q_pop ? q_entry.pos[CW-1:0] : scan_sum_slot[SW-1:1];
		rd_en_b   = scan_issue;
		rd_addr_b = scan_tdc_slot[SW-1:1];
	end

	// per-short update of the stored entry
	always_comb begin
		for (int b = 0; b < 2; b++) begin
			lane_slot[b]  = {acc_row_s1, 1'(b)};
			lane_short[b] = acc_word_s1[HW*(1-b) +: HW];
			lane_t[b]     = lane_short[b][TW-1:0];
			lane_ch[b]    = CW'(lane_slot[b] - SW'(CHANNELS));
			lane_hit[b]   = 1'b0;
			if (lane_slot[b] < SW'(CHANNELS)) begin
				lane_old[b] = vld_q[b][acc_row_s1] ? rd_a[b] : '0;
				lane_new[b] = lane_old[b];
				if (lane_short[b] > cfg.adc_threshold) begin
					lane_new[b][HW-1:0] = lane_old[b][HW-1:0] + lane_short[b];
				end
			end else begin
				lane_old[b] = vld_q[b][acc_row_s1] ? rd_a[b] : TDC_RST;
				lane_new[b] = lane_old[b];
				if ((lane_short[b] & whe_pkg::VALID_BIT) != '0 && lane_t[b] != '0
						&& lane_t[b] < lane_old[b][EW-1:TW]) begin
					lane_new[b] = {lane_t[b], lane_old[b][EW-1:TW]};
					lane_hit[b] = 1'b1;
				end
			end
		end
	end

	// hit fields of the channel in the scan stage
	always_comb begin
		sc_sum_slot = SW'(sc_ch_s1);
		sc_tdc_slot = SW'(sc_ch_s1) + SW'(CHANNELS);
		sc_sum  = vld_q[sc_sum_slot[0]][sc_sum_slot[SW-1:1]]
			? rd_a[sc_sum_slot[0]][HW-1:0] : '0;
		sc_tdc  = vld_q[sc_tdc_slot[0]][sc_tdc_slot[SW-1:1]]
			? rd_b[sc_tdc_slot[0]] : TDC_RST;
		sc_fast = {1'b0, sc_tdc[EW-1:TW]};
		sc_base = (cfg.trigger_time < sc_fast)
			? (cfg.trigger_time | whe_pkg::VALID_BIT) : cfg.trigger_time;
		sc_drift = sc_base - sc_fast + cfg.time_offset;
		sc_last  = (hit_mask_q & ~(CHANNELS'(1) << sc_ch_s1)) == '0;
		sc_chan  = whe_pkg::chan_t'(sc_ch_s1);
	end

	// two banks: even slots and odd slots, one row per word position
	for (genvar b = 0; b < 2; b++) begin : g_bank
		whe_ram #(
			.WIDTH (EW),
			.DEPTH (CHANNELS)
		) u_ram (
			.clk     (clk),
			.we      (acc_valid_s1),
			.waddr   (acc_row_s1),
			.wdata   (lane_new[b]),
			.rea     (rd_en_a),
			.raddr_a (rd_addr_a),
			.rdata_a (rd_a[b]),
			.reb     (rd_en_b),
			.raddr_b (rd_addr_b),
			.rdata_b (rd_b[b])
		);
	end

	// accumulation stage payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			acc_word_s1 <= q_entry.data_word;
			acc_row_s1  <= q_entry.pos[CW-1:0];
			acc_kind_s1 <= q_entry.kind;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_ERR && out_free) begin
			hit_word_q <= '{channel: '0, drift_time: '0, adc_sum: '0,
				second_time: '0, last_hit: 1'b1, length_error: 1'b1};
		end else if (state_q == ST_SCAN && sc_hit && out_free) begin
			hit_word_q <= '{channel: sc_chan, drift_time: sc_drift, adc_sum: sc_sum,
				second_time: {1'b0, sc_tdc[TW-1:0]} + cfg.time_offset,
				last_hit: sc_last, length_error: 1'b0};
		end
	end

	// sequencer: accumulate, scan at packet end, report a short packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			acc_valid_s1 <= 1'b0;
			vld_q[0]     <= '0;
			vld_q[1]     <= '0;
			hit_mask_q   <= '0;
			scan_issue_q <= 1'b0;
			scan_ch_q    <= '0;
			sc_valid_s1  <= 1'b0;
			sc_ch_s1     <= '0;
			hit_valid_q  <= 1'b0;
		end else begin
			if (hit_load) begin
				hit_valid_q <= 1'b1;
			end else if (hit_valid_q && !hit_stall) begin
				hit_valid_q <= 1'b0;
			end
			acc_valid_s1 <= q_pop;

			unique case (state_q)
				ST_RUN: begin
					if (acc_valid_s1) begin
						for (int b = 0; b < 2; b++) begin
							vld_q[b][acc_row_s1] <= 1'b1;
							if (lane_hit[b]) begin
								hit_mask_q[lane_ch[b]] <= 1'b1;
							end
						end
						if (acc_kind_s1 == whe_pkg::KIND_END) begin
							state_q      <= ST_SCAN;
							scan_issue_q <= 1'b1;
							scan_ch_q    <= '0;
						end else if (acc_kind_s1 == whe_pkg::KIND_ERR) begin
							state_q <= ST_ERR;
						end
					end
				end
				ST_SCAN: begin
					if (scan_adv) begin
						sc_valid_s1 <= scan_issue_q;
						sc_ch_s1    <= scan_ch_q;
					end
					if (scan_issue) begin
						scan_ch_q <= scan_ch_q + 1'b1;
						if (scan_ch_q == CW'(CHANNELS - 1)) begin
							scan_issue_q <= 1'b0;
						end
					end
					if (sc_hit && out_free) begin
						hit_mask_q[sc_ch_s1] <= 1'b0;
					end
					if (!scan_issue_q && !sc_valid_s1) begin
						vld_q[0]   <= '0;
						vld_q[1]   <= '0;
						hit_mask_q <= '0;
						state_q    <= ST_RUN;
					end
				end
				ST_ERR: begin
					if (out_free) begin
						vld_q[0]    <= '0;
						vld_q[1]    <= '0;
						hit_mask_q  <= '0;
						state_q     <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/waveform_hit_extractor_top.sv =====
// top level of the waveform hit extractor
//
// Payload channel (pay_valid, pay_stall, pay_word): one 32-bit raw-mode word per
// accepted word, high short first; last_word marks the end of the packet. A word
// is taken in every cycle while the four-entry queue behind the front has room.
// Hit channel (hit_valid, hit_stall, hit_word): after the last word of a packet
// one hit per channel with a tdc hit, in channel order, last_hit on the final
// one; a packet that ends inside a sample yields one word with length_error.
// Throughput: the back end accumulates one word per cycle through a read and a
// write of the two slot rams, except while it scans or reports an error. At
// packet end it scans the channels, one per cycle unless a hit waits for the
// output register, then clears the per-packet state; meanwhile the queue fills
// and then stalls the payload.
// A stalled hit_word holds and the scan waits on it, so stalls on the hit side
// back up through the queue to pay_stall. Reset empties the queue, clears all
// per-packet state (valid bits, no sweep) and loads the register defaults.
// Registers are written via cfg_we, cfg_index and cfg_data; the user must do so
// while the block is idle, which the block does not enforce. Index 3 is ignored.
`default_nettype none

module waveform_hit_extractor_top #(
	parameter int CHANNELS = whe_pkg::CHANNELS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            pay_valid,
	output logic                                 pay_stall,
	input  wire whe_pkg::pay_word_t              pay_word,
	output logic                                 hit_valid,
	input  wire logic                            hit_stall,
	output whe_pkg::hit_word_t                   hit_word,
	input  wire logic                            cfg_we,
	input  wire whe_pkg::reg_idx_t               cfg_index,
	input  wire logic [whe_pkg::SHORT_W-1:0]     cfg_data
);

	whe_pkg::cfg_t  cfg_q;
	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_valid;
	whe_pkg::qent_t q_in;
	whe_pkg::qent_t q_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.adc_threshold <= whe_pkg::ADC_THRESHOLD_RST;
			cfg_q.time_offset   <= whe_pkg::TIME_OFFSET_RST;
			cfg_q.trigger_time  <= whe_pkg::TRIGGER_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				whe_pkg::REG_ADC_THRESHOLD: cfg_q.adc_threshold <= cfg_data;
				whe_pkg::REG_TIME_OFFSET:   cfg_q.time_offset   <= cfg_data;
				whe_pkg::REG_TRIGGER_TIME:  cfg_q.trigger_time  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front: position tracking and classification
	whe_front #(
		.CHANNELS (CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pay_valid (pay_valid),
		.pay_stall (pay_stall),
		.pay_word  (pay_word),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_in)
	);

	// queue between front and back
	whe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_entry (q_head)
	);

	// back: accumulation, scan and hit output
	whe_back #(
		.CHANNELS (CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_entry   (q_head),
		.q_pop     (q_pop),
		.hit_valid (hit_valid),
		.hit_stall (hit_stall),
		.hit_word  (hit_word)
	);

	// back end never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	// an error word is always the final word of its packet
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && hit_word.length_error |-> hit_word.last_hit
			&& hit_word.adc_sum == '0 && hit_word.channel == '0)
		else $error("malformed length error word");

	// reported channel lies within the configured channel count
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid |-> (32'(hit_word.channel) < CHANNELS))
		else $error("hit channel out of range");

endmodule

`default_nettype wire

// ===== tb/sv/waveform_hit_extractor_top_test.sv =====
// self-checking testbench for the waveform hit extractor top level
`default_nettype none

module waveform_hit_extractor_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_CH         = whe_pkg::CHANNELS_DEF;
	localparam int SAMPLE_WORDS = N_CH;          // two shorts per word, 2*N_CH shorts
	localparam int DRAIN_CYCLES = 3 * N_CH;      // scan, clear and queue slack
	localparam int RAND_WORDS   = 380;
	localparam int LONG_HOLD    = 300;
	localparam whe_pkg::reg_idx_t REG_UNUSED = 2'd3;

	// expected hit bookkeeping and behavioral prediction
	class hit_ledger;
		logic [whe_pkg::SHORT_W-1:0] thr;
		logic [whe_pkg::SHORT_W-1:0] offs;
		logic [whe_pkg::SHORT_W-1:0] trig;
		logic [whe_pkg::POS_W-1:0]   pos;
		logic [whe_pkg::SHORT_W-1:0] sums [N_CH];
		logic [whe_pkg::TIME_W-1:0]  fastest_t [N_CH];
		logic [whe_pkg::TIME_W-1:0]  second_t [N_CH];
		whe_pkg::hit_word_t          due [$];
		int                          fail_count;

		function new();
			thr = whe_pkg::ADC_THRESHOLD_RST;
			offs = whe_pkg::TIME_OFFSET_RST;
			trig = whe_pkg::TRIGGER_TIME_RST;
			fail_count = 0;
			clear_packet();
		endfunction

		function void clear_packet();
			pos = '0;
			for (int c = 0; c < N_CH; c++) begin
				sums[c] = '0;
				fastest_t[c] = whe_pkg::NO_TIME;
				second_t[c] = whe_pkg::NO_TIME;
			end
		endfunction

		// append one expected word at the tail
		function void enqueue_hit(whe_pkg::hit_word_t h);
			due = {due, h};
		endfunction

		function void write_reg(whe_pkg::reg_idx_t idx, logic [whe_pkg::SHORT_W-1:0] v);
			case (idx)
				whe_pkg::REG_ADC_THRESHOLD: thr = v;
				whe_pkg::REG_TIME_OFFSET: offs = v;
				whe_pkg::REG_TRIGGER_TIME: trig = v;
				default: ;
			endcase
		endfunction

		// adc slots accumulate, tdc slots track fastest and runner-up
		function void take_short(int slot, logic [whe_pkg::SHORT_W-1:0] v);
			int ch;
			logic [whe_pkg::TIME_W-1:0] t;
			if (slot < N_CH) begin
				if (v > thr)
					sums[slot] = sums[slot] + v;
			end else begin
				ch = slot - N_CH;
				t = v[whe_pkg::TIME_W-1:0];
				if (v[whe_pkg::SHORT_W-1] && t != '0 && t < fastest_t[ch]) begin
					second_t[ch] = fastest_t[ch];
					fastest_t[ch] = t;
				end
			end
		endfunction

		function void note_word(whe_pkg::pay_word_t w);
			whe_pkg::hit_word_t h;
			whe_pkg::hit_word_t held;
			bit have;
			logic [whe_pkg::SHORT_W-1:0] f;
			logic [whe_pkg::SHORT_W-1:0] d;
			have = 0;
			take_short(2 * pos, w.data_word[31:16]);
			take_short(2 * pos + 1, w.data_word[15:0]);
			pos = (pos + 1 >= N_CH) ? '0 : pos + 1'b1;
			if (!w.last_word)
				return;
			// packet cut inside a sample: one error word only
			if (pos != '0) begin
				h = '0;
				h.last_hit = 1'b1;
				h.length_error = 1'b1;
				enqueue_hit(h);
				clear_packet();
				return;
			end
			for (int c = 0; c < N_CH; c++) begin
				if (fastest_t[c] != whe_pkg::NO_TIME) begin
					f = {1'b0, fastest_t[c]};
					d = (trig < f) ? ((trig | whe_pkg::VALID_BIT) - f) : (trig - f);
					h.channel = whe_pkg::chan_t'(c);
					h.drift_time = d + offs;
					h.adc_sum = sums[c];
					h.second_time = {1'b0, second_t[c]} + offs;
					h.last_hit = 1'b0;
					h.length_error = 1'b0;
					if (have)
						enqueue_hit(held);
					held = h;
					have = 1;
				end
			end
			if (have) begin
				held.last_hit = 1'b1;
				enqueue_hit(held);
			end
			clear_packet();
		endfunction

		function void field_check(string name, logic [whe_pkg::SHORT_W-1:0] exp_v,
				logic [whe_pkg::SHORT_W-1:0] got_v);
			if (exp_v !== got_v) begin
				$display("%0t: hit %s expected %0h actual %0h", $time, name, exp_v, got_v);
				fail_count++;
			end
		endfunction

		function void check_hit(whe_pkg::hit_word_t got);
			whe_pkg::hit_word_t exp_h;
			if (due.size() == 0) begin
				$display("%0t: unexpected hit word, expected none actual %0h", $time, got);
				fail_count++;
				return;
			end
			exp_h = due.pop_front();
			field_check("channel", 16'(exp_h.channel), 16'(got.channel));
			field_check("drift_time", exp_h.drift_time, got.drift_time);
			field_check("adc_sum", exp_h.adc_sum, got.adc_sum);
			field_check("second_time", exp_h.second_time, got.second_time);
			field_check("last_hit", 16'(exp_h.last_hit), 16'(got.last_hit));
			field_check("length_error", 16'(exp_h.length_error), 16'(got.length_error));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               pay_valid;
	logic               pay_stall;
	whe_pkg::pay_word_t pay_word;
	logic               hit_valid;
	logic               hit_stall;
	whe_pkg::hit_word_t hit_word;
	logic               cfg_we;
	whe_pkg::reg_idx_t  cfg_index;
	logic [whe_pkg::SHORT_W-1:0] cfg_data;

	hit_ledger ledger = new();
	bit        tx_calm;
	int        words_sent;

	waveform_hit_extractor_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pay_valid (pay_valid),
		.pay_stall (pay_stall),
		.pay_word  (pay_word),
		.hit_valid (hit_valid),
		.hit_stall (hit_stall),
		.hit_word  (hit_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1ns clk = ~clk;

	// hit monitor
	always @(posedge clk) begin
		if (arst_n && hit_valid && !hit_stall)
			ledger.check_hit(hit_word);
	end

	// hit side stalls, with one long hold-off early on
	initial begin : drain_proc
		int gap;
		int taken;
		bit rx_calm;
		taken = 0;
		rx_calm = 0;
		hit_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken % 32 == 0)
				rx_calm = ($urandom_range(0, 2) == 0);
			gap = rx_calm ? 0 : $urandom_range(0, 13);
			if (taken == 5)
				gap = LONG_HOLD;
			if (gap > 0) begin
				hit_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				hit_stall <= 1'b0;
			end
			@(posedge clk);
			while (!(hit_valid && !hit_stall)) @(posedge clk);
			taken++;
		end
	end

	// timeout
	initial begin
		#1_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic send_word(input whe_pkg::pay_word_t w);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			pay_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pay_valid <= 1'b1;
		pay_word <= w;
		@(posedge clk);
		while (pay_stall) @(posedge clk);
		ledger.note_word(w);
		words_sent++;
	endtask

	function automatic logic [whe_pkg::SHORT_W-1:0] adc_short();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return ledger.thr;
			2: return ledger.thr + 16'd1;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// density is the percentage of shorts that carry a usable time
	function automatic logic [whe_pkg::SHORT_W-1:0] tdc_short(int density);
		if ($urandom_range(0, 99) >= density) begin
			case ($urandom_range(0, 3))
				0: return 16'h0000;
				1: return whe_pkg::VALID_BIT;
				2: return {1'b0, 15'($urandom)};
				default: return 16'hffff;  // valid but never below the idle time
			endcase
		end
		case ($urandom_range(0, 5))
			0: return 16'h8001;
			1: return 16'hfffe;
			2: return {1'b1, ledger.trig[whe_pkg::TIME_W-1:0]};
			3: return {1'b1, ledger.trig[whe_pkg::TIME_W-1:0] + 15'd1};
			default: return {1'b1, 15'($urandom)};
		endcase
	endfunction

	task automatic send_packet(input int n_words, input int density);
		int slot;
		logic [whe_pkg::SHORT_W-1:0] hi;
		logic [whe_pkg::SHORT_W-1:0] lo;
		whe_pkg::pay_word_t w;
		tx_calm = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n_words; i++) begin
			slot = (2 * i) % (2 * N_CH);
			hi = (slot < N_CH) ? adc_short() : tdc_short(density);
			lo = (slot + 1 < N_CH) ? adc_short() : tdc_short(density);
			w.data_word = {hi, lo};
			w.last_word = (i == n_words - 1);
			send_word(w);
		end
	endtask

	// every expected hit in, then let a silent scan finish
	task automatic wait_drained();
		while (ledger.due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [whe_pkg::SHORT_W-1:0] thr, off, trig);
		whe_pkg::reg_idx_t idx [4];
		logic [whe_pkg::SHORT_W-1:0] val [4];
		idx = '{whe_pkg::REG_ADC_THRESHOLD, whe_pkg::REG_TIME_OFFSET,
			whe_pkg::REG_TRIGGER_TIME, REG_UNUSED};
		val = '{thr, off, trig, 16'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			ledger.write_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin : stim_proc
		whe_pkg::pay_word_t w;
		int ph;
		int kind;
		int len;
		arst_n <= 1'b0;
		pay_valid <= 1'b0;
		pay_word <= '0;
		cfg_we <= 1'b0;
		cfg_index <= whe_pkg::REG_ADC_THRESHOLD;
		cfg_data <= '0;
		tx_calm = 0;
		words_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short packets cut inside a sample, all-ones and all-zero words
		w.data_word = 32'hffff_ffff;
		w.last_word = 1'b1;
		send_word(w);
		w.data_word = 32'h0000_0000;
		send_word(w);
		send_packet(21, 50);

		// random packets, register settings change between phases
		ph = 0;
		while (words_sent < RAND_WORDS) begin
			if (ph > 0) begin
				pay_valid <= 1'b0;
				wait_drained();
				case (ph)
					1: program_regs(16'h0000, 16'h0000, 16'h0000);
					2: program_regs(16'hffff, 16'hffff, 16'hffff);
					default: program_regs(16'($urandom_range(0, 600)), 16'($urandom),
						16'($urandom));
				endcase
			end
			for (int p = 0; p < 2 && words_sent < RAND_WORDS; p++) begin
				kind = (ph == 0 && p == 0) ? 9 : $urandom_range(0, 9);
				case (kind)
					0: begin
						len = $urandom_range(1, 2 * SAMPLE_WORDS - 1);
						if (len == SAMPLE_WORDS)
							len++;
						send_packet(len, 50);
					end
					1: send_packet(SAMPLE_WORDS, 0);
					2, 3: send_packet(2 * SAMPLE_WORDS, 40);
					default: send_packet(SAMPLE_WORDS, $urandom_range(10, 90));
				endcase
			end
			ph++;
		end
		pay_valid <= 1'b0;

		wait_drained();
		if (ledger.fail_count == 0 && ledger.due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
